>>> rtl/u8nv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8nv_pkg
// Shared types, constants and code point checks for the UTF-8 name validator.
// ----------------------------------------------------------------------------
package u8nv_pkg;

	localparam int unsigned LEN_W      = 11;
	localparam int unsigned MAX_W      = 10;
	localparam int unsigned CP_W       = 21;

	localparam logic [LEN_W-1:0] COUNT_SAT      = 11'd1024;
	localparam logic [MAX_W-1:0] MAX_BYTES_RST  = 10'd32;

	localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
	localparam logic [CP_W-1:0] CP_MIN_2B    = 21'h000080;
	localparam logic [CP_W-1:0] CP_MIN_3B    = 21'h000800;
	localparam logic [CP_W-1:0] CP_MIN_4B    = 21'h010000;
	localparam logic [CP_W-1:0] CP_SPACE     = 21'h000020;
	localparam logic [CP_W-1:0] CP_DEL       = 21'h00007F;
	localparam logic [CP_W-1:0] CP_C1_HI     = 21'h00009F;
	localparam logic [CP_W-1:0] CP_LSEP      = 21'h002028;
	localparam logic [CP_W-1:0] CP_PSEP      = 21'h002029;
	localparam logic [CP_W-1:0] CP_BIDI_LO   = 21'h00202A;
	localparam logic [CP_W-1:0] CP_BIDI_HI   = 21'h00202E;
	localparam logic [CP_W-1:0] CP_ISO_LO    = 21'h002066;
	localparam logic [CP_W-1:0] CP_ISO_HI    = 21'h002069;
	localparam logic [CP_W-1:0] CP_ALM       = 21'h00061C;
	localparam logic [CP_W-1:0] CP_LRM       = 21'h00200E;
	localparam logic [CP_W-1:0] CP_RLM       = 21'h00200F;

	// Continuation counts of a sequence
	localparam logic [1:0] SEQ_NONE = 2'd0;
	localparam logic [1:0] SEQ_TWO  = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR = 2'd3;

	typedef struct packed {
		logic [1:0]       pend;
		logic [1:0]       seqlen;
		logic [CP_W-1:0]  acc;
		logic [LEN_W-1:0] cnt;
		logic             fail;
	} name_state_t;

	function automatic logic cp_forbidden(input logic [CP_W-1:0] cp);
		logic r;
		r = (cp < CP_SPACE)
			|| (cp >= CP_DEL && cp <= CP_C1_HI)
			|| (cp == CP_LSEP) || (cp == CP_PSEP)
			|| (cp >= CP_BIDI_LO && cp <= CP_BIDI_HI)
			|| (cp >= CP_ISO_LO && cp <= CP_ISO_HI)
			|| (cp == CP_ALM) || (cp == CP_LRM) || (cp == CP_RLM);
		return r;
	endfunction

	function automatic logic cp_bad(input logic [CP_W-1:0] cp, input logic [1:0] conts);
		logic r;
		r = (conts == SEQ_TWO && cp < CP_MIN_2B)
			|| (conts == SEQ_THREE && cp < CP_MIN_3B)
			|| (conts == SEQ_FOUR && cp < CP_MIN_4B)
			|| (cp > CP_MAX)
			|| (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
			|| cp_forbidden(cp);
		return r;
	endfunction

endpackage

>>> rtl/u8nv_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8nv_step
// Next-state logic for one beat: decode the byte, update the sequence state,
// count it and form the verdict on the last beat of a name.
// ----------------------------------------------------------------------------
module u8nv_step
	import u8nv_pkg::*;
(
	input  name_state_t      cur,
	input  logic             has_byte,
	input  logic [7:0]       byte_value,
	input  logic             last,
	input  logic [MAX_W-1:0] max_bytes,
	output name_state_t      nxt,
	output logic             verdict,
	output logic [LEN_W-1:0] length
);

	name_state_t     upd;
	logic [CP_W-1:0] acc_sh;

	always_comb begin
		upd    = cur;
		acc_sh = {cur.acc[CP_W-7:0], byte_value[5:0]};
		if (has_byte) begin
			if (cur.cnt < COUNT_SAT) begin
				upd.cnt = cur.cnt + 1'b1;
			end
			if (cur.pend != SEQ_NONE) begin
				if (byte_value[7:6] != 2'b10) begin
					upd.fail   = 1'b1;
					upd.pend   = SEQ_NONE;
					upd.seqlen = SEQ_NONE;
					upd.acc    = '0;
				end else begin
					upd.acc  = acc_sh;
					upd.pend = cur.pend - 1'b1;
					// sequence complete: check the assembled code point
					if (cur.pend == SEQ_TWO) begin
						upd.seqlen = SEQ_NONE;
						upd.acc    = '0;
						if (cp_bad(acc_sh, cur.seqlen)) begin
							upd.fail = 1'b1;
						end
					end
				end
			end else if (!byte_value[7]) begin
				if (cp_forbidden({13'd0, byte_value})) begin
					upd.fail = 1'b1;
				end
			end else if (byte_value[7:5] == 3'b110) begin
				upd.acc    = {16'd0, byte_value[4:0]};
				upd.pend   = SEQ_TWO;
				upd.seqlen = SEQ_TWO;
			end else if (byte_value[7:4] == 4'b1110) begin
				upd.acc    = {17'd0, byte_value[3:0]};
				upd.pend   = SEQ_THREE;
				upd.seqlen = SEQ_THREE;
			end else if (byte_value[7:3] == 5'b11110) begin
				upd.acc    = {18'd0, byte_value[2:0]};
				upd.pend   = SEQ_FOUR;
				upd.seqlen = SEQ_FOUR;
			end else begin
				upd.fail   = 1'b1;
				upd.pend   = SEQ_NONE;
				upd.seqlen = SEQ_NONE;
				upd.acc    = '0;
			end
		end

		verdict = !upd.fail && (upd.pend == SEQ_NONE) && (upd.cnt != '0)
			&& (upd.cnt <= {1'b0, max_bytes});
		length  = upd.cnt;

		// clear for the next name after the verdict
		nxt = last ? '0 : upd;
	end

endmodule

>>> rtl/utf8_name_validator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_name_validator_top
// Checks a name one byte per beat for length limit, well-formed UTF-8 and
// forbidden code points; gives one verdict beat per name.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   input   | in_valid / in_stall    | has_byte, byte_value, last
//   output  | out_valid / out_stall  | name_valid, name_length
//   config  | cfg_wr_en              | cfg_wr_data (max_name_bytes)
//
// One input beat per cycle while in_stall is low; the verdict of a name is offered
// after its last beat passes the input register, then the result register.
// Reset clears the name state and loads a limit of 32 bytes.
// A stalled verdict holds the result register; only a last beat waits on
// it, other beats keep flowing through the decoder.
// ----------------------------------------------------------------------------
module utf8_name_validator_top
	import u8nv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [MAX_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             has_byte,
	input  logic [7:0]       byte_value,
	input  logic             last,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             name_valid,
	output logic [LEN_W-1:0] name_length
);

	logic [MAX_W-1:0] max_q;
	name_state_t      st_q;
	name_state_t      st_nxt;

	logic             valid_s1;
	logic             has_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	logic             out_valid_q;
	logic             name_valid_q;
	logic [LEN_W-1:0] name_length_q;

	logic             verdict;
	logic [LEN_W-1:0] length;
	logic             out_free;
	logic             fire;

	assign out_free = !out_valid_q || !out_stall;
	// only a last beat needs room in the result register
	assign fire     = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_BYTES_RST;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			has_s1  <= has_byte;
			byte_s1 <= byte_value;
			last_s1 <= last;
		end
	end

	u8nv_step u_step (
		.cur        (st_q),
		.has_byte   (has_s1),
		.byte_value (byte_s1),
		.last       (last_s1),
		.max_bytes  (max_q),
		.nxt        (st_nxt),
		.verdict    (verdict),
		.length     (length)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			name_valid_q  <= verdict;
			name_length_q <= length;
		end
	end

	assign out_valid   = out_valid_q;
	assign name_valid  = name_valid_q;
	assign name_length = name_length_q;

	a_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (name_length_q <= COUNT_SAT))
		else $error("name length above saturation");

	a_valid_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && name_valid_q) |-> (name_length_q != '0))
		else $error("empty name reported valid");

	a_pend_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.pend != SEQ_NONE) |-> (st_q.seqlen >= st_q.pend))
		else $error("pending continuations exceed sequence length");

	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cnt <= COUNT_SAT)
		else $error("byte counter past saturation");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> (valid_s1 && $stable(byte_s1) && $stable(last_s1)))
		else $error("input register lost a waiting beat");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives names into the UTF-8 name validator one byte per beat and checks
// each verdict against a bit-level predictor of the decoder and length
// limit. Directed names cover the encoding corner cases, then length limits,
// back-to-back traffic, a long output hold-off and a bulk of random names.
// ----------------------------------------------------------------------------
module testbench
	import u8nv_pkg::*;
();

	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned LONG_HOLD     = 120;
	localparam int unsigned RANDOM_BEATS  = 120;
	localparam int unsigned RANDOM_NAMES  = 10;

	typedef logic [7:0] octets_t[$];

	typedef struct packed {
		logic             ok;
		logic [LEN_W-1:0] len;
	} verdict_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [MAX_W-1:0] cfg_wr_data = '0;
	logic             in_valid    = 1'b0;
	logic             in_stall;
	logic             has_byte    = 1'b0;
	logic [7:0]       byte_value  = 8'h00;
	logic             last        = 1'b0;
	logic             out_valid;
	logic             out_stall   = 1'b0;
	logic             name_valid;
	logic [LEN_W-1:0] name_length;

	// Predicted decoder state, updated at every accepted beat
	logic [1:0]       dec_pending = SEQ_NONE;
	logic [1:0]       dec_conts   = SEQ_NONE;
	logic [CP_W-1:0]  dec_cp      = '0;
	logic [LEN_W-1:0] dec_count   = '0;
	bit               dec_failed  = 1'b0;
	logic [MAX_W-1:0] name_limit  = MAX_BYTES_RST;

	verdict_t    pending_verdicts[$];
	int unsigned mismatches      = 0;
	int unsigned verdicts_seen   = 0;
	int unsigned byte_beats      = 0;
	int unsigned names_sent      = 0;
	int unsigned limit_writes    = 0;
	int unsigned quiet_cycles    = 0;
	int unsigned holds_asked     = 0;
	int unsigned holds_served    = 0;
	bit          tx_calm         = 1'b0;
	bit          rx_calm         = 1'b0;

	utf8_name_validator_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.has_byte   (has_byte),
		.byte_value (byte_value),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.name_valid (name_valid),
		.name_length(name_length)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic bit banned_cp(input logic [CP_W-1:0] cp);
		return cp < 'h20 || (cp >= 'h7F && cp <= 'h9F)
			|| cp == 'h2028 || cp == 'h2029
			|| (cp >= 'h202A && cp <= 'h202E)
			|| (cp >= 'h2066 && cp <= 'h2069)
			|| cp == 'h061C || cp == 'h200E || cp == 'h200F;
	endfunction

	function automatic bit rejected_cp(input logic [CP_W-1:0] cp, input logic [1:0] conts);
		if (conts == SEQ_TWO && cp < 'h80)
			return 1'b1;
		if (conts == SEQ_THREE && cp < 'h800)
			return 1'b1;
		if (conts == SEQ_FOUR && cp < 'h10000)
			return 1'b1;
		if (cp > 'h10FFFF || (cp >= 'hD800 && cp <= 'hDFFF))
			return 1'b1;
		return banned_cp(cp);
	endfunction

	function automatic void drop_sequence();
		dec_pending = SEQ_NONE;
		dec_conts   = SEQ_NONE;
		dec_cp      = '0;
	endfunction

	function automatic void latch_failure();
		dec_failed = 1'b1;
		drop_sequence();
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		if (dec_count < COUNT_SAT)
			dec_count++;
		if (dec_pending != SEQ_NONE) begin
			if (b[7:6] != 2'b10) begin
				latch_failure();
				return;
			end
			dec_cp = {dec_cp[CP_W-7:0], b[5:0]};
			dec_pending--;
			if (dec_pending == SEQ_NONE) begin
				if (rejected_cp(dec_cp, dec_conts))
					latch_failure();
				else
					drop_sequence();
			end
		end else if (!b[7]) begin
			if (banned_cp({13'd0, b}))
				latch_failure();
		end else if (b[7:5] == 3'b110) begin
			dec_cp      = {16'd0, b[4:0]};
			dec_pending = SEQ_TWO;
			dec_conts   = SEQ_TWO;
		end else if (b[7:4] == 4'b1110) begin
			dec_cp      = {17'd0, b[3:0]};
			dec_pending = SEQ_THREE;
			dec_conts   = SEQ_THREE;
		end else if (b[7:3] == 5'b11110) begin
			dec_cp      = {18'd0, b[2:0]};
			dec_pending = SEQ_FOUR;
			dec_conts   = SEQ_FOUR;
		end else begin
			latch_failure();
		end
	endfunction

	function automatic void close_name();
		verdict_t v;
		v.ok  = !dec_failed && dec_pending == SEQ_NONE && dec_count != 0
			&& dec_count <= {1'b0, name_limit};
		v.len = dec_count;
		pending_verdicts.insert(pending_verdicts.size(), v);
		drop_sequence();
		dec_count  = '0;
		dec_failed = 1'b0;
	endfunction

	function automatic void flag(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	// Check the output side first so a verdict never meets its own name
	always @(posedge clk) begin
		verdict_t want;
		if (out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				flag($sformatf("verdict with no name pending: valid=%0d length=%0d",
					name_valid, name_length));
			end else begin
				want = pending_verdicts[0];
				pending_verdicts.delete(0);
				verdicts_seen++;
				if (name_valid !== want.ok)
					flag($sformatf("name %0d: name_valid expected %0d, got %0d",
						verdicts_seen, want.ok, name_valid));
				if (name_length !== want.len)
					flag($sformatf("name %0d: name_length expected %0d, got %0d",
						verdicts_seen, want.len, name_length));
			end
		end
		if (cfg_wr_en)
			name_limit = cfg_wr_data;
		if (in_valid && !in_stall) begin
			if (has_byte) begin
				byte_beats++;
				decode_byte(byte_value);
			end
			if (last)
				close_name();
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
			$display("testbench: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Idling on both sides
	// ------------------------------------------------------------------
	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin : receiver
		int unsigned gap;
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_calm) begin
				out_stall <= 1'b0;
			end else begin
				gap = draw_gap();
				if (gap == 0) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Valid stays high between beats unless an idle gap is drawn; the caller drops it at the end of a phase
	task automatic send_beat(input bit has, input logic [7:0] b, input bit lst);
		int unsigned gap;
		gap = tx_calm ? 0 : draw_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		has_byte   <= has;
		byte_value <= b;
		last       <= lst;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_name(input octets_t bytes);
		bit split_end;
		split_end = bytes.size() == 0 || $urandom_range(0, 9) == 0;
		foreach (bytes[i]) begin
			if ($urandom_range(0, 19) == 0)
				send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b0);
			send_beat(1'b1, bytes[i], !split_end && i == bytes.size() - 1);
		end
		// end the name with a byte-less beat
		if (split_end)
			send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b1);
		names_sent++;
	endtask

	task automatic send_ascii_name(input int unsigned len);
		octets_t q;
		repeat (len) q.insert(q.size(), 8'($urandom_range('h20, 'h7E)));
		send_name(q);
	endtask

	// Drop valid and let the last accepted beat be predicted before the queue is checked
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [MAX_W-1:0] v);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_writes++;
	endtask

	// ------------------------------------------------------------------
	// Name builders
	// ------------------------------------------------------------------
	// Encode cp in the given byte count; short counts of large values and
	// long counts of small values give broken or overlong forms on purpose
	function automatic void put_utf8(ref octets_t q, input logic [31:0] cp,
		input int unsigned width);
		case (width)
			1: q.insert(q.size(), cp[7:0]);
			2: begin
				q.insert(q.size(), {3'b110, cp[10:6]});
				q.insert(q.size(), {2'b10, cp[5:0]});
			end
			3: begin
				q.insert(q.size(), {4'b1110, cp[15:12]});
				q.insert(q.size(), {2'b10, cp[11:6]});
				q.insert(q.size(), {2'b10, cp[5:0]});
			end
			default: begin
				q.insert(q.size(), {5'b11110, cp[20:18]});
				q.insert(q.size(), {2'b10, cp[17:12]});
				q.insert(q.size(), {2'b10, cp[11:6]});
				q.insert(q.size(), {2'b10, cp[5:0]});
			end
		endcase
	endfunction

	task automatic put_char(ref octets_t q, input int unsigned width);
		logic [31:0] cp;
		do begin
			case (width)
				1: cp = $urandom_range('h20, 'h7E);
				2: cp = $urandom_range('hA0, 'h7FF);
				3: cp = $urandom_range('h800, 'hFFFF);
				default: cp = $urandom_range('h10000, 'h10FFFF);
			endcase
		end while (banned_cp(cp) || (cp >= 'hD800 && cp <= 'hDFFF));
		put_utf8(q, cp, width);
	endtask

	task automatic put_defect(ref octets_t q);
		logic [31:0] cp;
		int unsigned w;
		case ($urandom_range(0, 6))
			0: begin
				case ($urandom_range(0, 5))
					0: cp = $urandom_range(0, 'h1F);
					1: cp = $urandom_range('h7F, 'h9F);
					2: cp = $urandom_range('h2028, 'h202E);
					3: cp = $urandom_range('h2066, 'h2069);
					4: cp = 'h061C;
					default: cp = $urandom_range('h200E, 'h200F);
				endcase
				put_utf8(q, cp, cp < 'h80 ? 1 : cp < 'h800 ? 2 : 3);
			end
			1: put_utf8(q, $urandom_range('hD800, 'hDFFF), 3);
			2: begin
				w = $urandom_range(2, 4);
				put_utf8(q, $urandom_range(0, w == 2 ? 'h7F : w == 3 ? 'h7FF : 'hFFFF), w);
			end
			3: put_utf8(q, $urandom_range('h110000, 'h1FFFFF), 4);
			4: begin
				// cut a sequence short
				w = $urandom_range(2, 4);
				put_char(q, w);
				repeat ($urandom_range(1, w - 1)) void'(q.pop_back());
			end
			5: q.insert(q.size(), 8'($urandom_range('h80, 'hBF)));
			default: q.insert(q.size(), 8'($urandom_range('hF8, 'hFF)));
		endcase
	endtask

	task automatic build_name(output octets_t q);
		int unsigned kind, chars, spot;
		q = {};
		kind  = $urandom_range(0, 99);
		chars = $urandom_range(0, 9) == 0 ? $urandom_range(8, 30) : $urandom_range(1, 6);
		if (kind < 15) begin
			repeat ($urandom_range(1, 10)) q.insert(q.size(), 8'($urandom_range(0, 255)));
			return;
		end
		spot = $urandom_range(0, chars - 1);
		for (int i = 0; i < chars; i++) begin
			if (kind >= 65 && i == spot)
				put_defect(q);
			else
				put_char(q, $urandom_range(1, 4));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed_cases();
		send_ascii_name(0);
		send_beat(1'b0, 8'hFF, 1'b0);
		send_name('{8'h41});
		send_name('{8'h7E});
		send_name('{8'h1F});
		send_name('{8'hFF});
		send_name('{8'hC2, 8'hA0});
		send_name('{8'hF4, 8'h8F, 8'hBF, 8'hBF});
		send_name('{8'hF4, 8'h90, 8'h80, 8'h80});
		send_name('{8'hED, 8'hA0, 8'h80});
		send_name('{8'hE0, 8'h80, 8'h80});
		send_name('{8'hE2, 8'h82});
		send_name('{8'hC3, 8'h41});
		send_name('{8'h80});
		send_name('{8'hE2, 8'h80, 8'hA8});
		wait_idle();
	endtask

	task automatic test_length_limits();
		int unsigned lim;
		// reset limit first
		send_ascii_name(32);
		send_ascii_name(33);
		set_limit(10'd1);
		send_ascii_name(0);
		send_ascii_name(1);
		send_ascii_name(2);
		set_limit(10'd0);
		send_ascii_name(1);
		send_ascii_name(3);
		set_limit(10'd5);
		send_ascii_name(4);
		send_ascii_name(5);
		send_ascii_name(6);
		lim = $urandom_range(6, 20);
		set_limit(MAX_W'(lim));
		send_ascii_name(lim - 1);
		send_ascii_name(lim);
		send_ascii_name(lim + 1);
		set_limit(10'd1023);
		send_ascii_name(24);
		wait_idle();
	endtask

	task automatic test_back_to_back();
		octets_t q;
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		set_limit(10'd40);
		repeat (6) begin
			build_name(q);
			send_name(q);
		end
		wait_idle();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	task automatic test_backpressure();
		tx_calm = 1'b1;
		holds_asked++;
		repeat (15) send_ascii_name($urandom_range(1, 3));
		wait_idle();
		tx_calm = 1'b0;
	endtask

	task automatic test_random_names();
		octets_t q;
		int unsigned start_beats, n, r;
		start_beats = byte_beats;
		n = 0;
		while (byte_beats - start_beats < RANDOM_BEATS || n < RANDOM_NAMES) begin
			if (n % 16 == 0) begin
				r = $urandom_range(0, 9);
				set_limit(r == 0 ? 10'd1 : r == 1 ? 10'd1023
					: MAX_W'($urandom_range(2, 40)));
				tx_calm = $urandom_range(0, 4) == 0;
				rx_calm = $urandom_range(0, 4) == 0;
			end
			build_name(q);
			send_name(q);
			n++;
		end
		wait_idle();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_length_limits();
		test_back_to_back();
		test_backpressure();
		test_random_names();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("covered %0d names, %0d byte beats, %0d limit writes incl. 0, 1 and 1023",
			names_sent, byte_beats, limit_writes);
		$display("checked %0d verdicts, %0d mismatches", verdicts_seen, mismatches);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
